// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

// ===== hw/rtl/epht_pkg.sv =====
package epht_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_MAX       = 32;

    localparam logic signed [33:0] ANG_TWO_PI = 34'sd1686629713;
    localparam logic signed [33:0] ANG_PI     = 34'sd843314857;

    // atan(2^-i) in Q4.28, rounded to nearest
    localparam logic [27:0] ATAN_LUT [CORDIC_MAX] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879,   28'd4193963,   28'd2097109,  28'd1048571,  28'd524287,
        28'd262144,    28'd131072,    28'd65536,    28'd32768,    28'd16384,
        28'd8192,      28'd4096,      28'd2048,     28'd1024,     28'd512,
        28'd256,       28'd128,       28'd64,       28'd32,       28'd16,
        28'd8,         28'd4,         28'd2,        28'd1,        28'd0,
        28'd0,         28'd0
    };

    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_RADIUS_X    = 3'd2,
        REG_RADIUS_Y    = 3'd3,
        REG_START_ANGLE = 3'd4,
        REG_SWEEP_ANGLE = 3'd5
    } t_cfg_idx;

    // fields riding along the divider
    typedef struct packed {
        logic [31:0] other;
        logic        nx;
        logic        ny;
        logic        far;
    } t_carry;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] q;
        t_carry      c;
    } t_div_st;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        nx;
        logic        ny;
        logic        in_circ;
    } t_norm_st;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
        logic               zero;
        logic               in_circ;
    } t_cordic_st;

endpackage

// ===== hw/rtl/elliptic_pie_hit_test.sv =====
// Tests one Q16.16 point per cycle against a pie sector of an axis-aligned
// ellipse set by six registers (center, radii, Q4.28 start and sweep). The
// pipeline takes a new item every cycle while it is not stalled: 2 entry
// stages, a 32-cell restoring divider that stretches the short axis, 2
// distance stages, 5 normalize cells, one CORDIC setup stage, one cell per
// CORDIC step, 3 angle wrap stages and the output register. Derived register
// values settle through their own registers after a write.
// Input stalls only while the output holds an item not yet taken and the last
// stage is full.
`include "assert_macros.svh"

module elliptic_pie_hit_test import epht_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [31:0] point_x, [63:32] point_y
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] hit, [7:1] zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

    // configuration
    logic [31:0] r_cx, r_cy, r_rx, r_ry, r_start, r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_start <= '0;
            r_sweep <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_CENTER_X:    r_cx    <= i_cfg_data;
                REG_CENTER_Y:    r_cy    <= i_cfg_data;
                REG_RADIUS_X:    r_rx    <= i_cfg_data;
                REG_RADIUS_Y:    r_ry    <= i_cfg_data;
                REG_START_ANGLE: r_start <= i_cfg_data;
                REG_SWEEP_ANGLE: r_sweep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // derived values
    logic [31:0]        mrx, mry;
    logic [31:0]        r_long, r_short;
    logic               r_sy, r_zr;
    logic [63:0]        r_big_sq;
    logic signed [33:0] sw_s, st_s;
    logic               r_full;
    logic signed [33:0] r_sw_abs, r_st0, r_st1, r_st2;

    assign mrx  = r_rx[31] ? (~r_rx + 32'd1) : r_rx;
    assign mry  = r_ry[31] ? (~r_ry + 32'd1) : r_ry;
    assign sw_s = 34'(signed'(r_sweep));
    assign st_s = 34'(signed'(r_start));

    function automatic logic signed [33:0] f_trunc_wrap(input logic signed [33:0] v);
        logic signed [33:0] res;
        res = v;
        if (v >= ANG_TWO_PI) begin
            res = v - ANG_TWO_PI;
        end else if (v <= -ANG_TWO_PI) begin
            res = v + ANG_TWO_PI;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        r_sy     <= mrx > mry;
        r_long   <= (mrx > mry) ? mrx : mry;
        r_short  <= (mrx > mry) ? mry : mrx;
        r_zr     <= (mrx == 32'd0) || (mry == 32'd0);
        r_big_sq <= 64'(r_long) * 64'(r_long);
        r_full   <= (sw_s < -ANG_TWO_PI) || (sw_s > ANG_TWO_PI);
        r_sw_abs <= (sw_s < 0) ? -sw_s : sw_s;
        r_st0    <= (sw_s < 0) ? st_s + sw_s : st_s;
        r_st1    <= f_trunc_wrap(r_st0);
        r_st2    <= f_trunc_wrap(r_st1);
    end

    // pipeline advance: holds only when the output is blocked and the last stage is full
    logic ce;
    logic r_out_valid, r_out_hit;
    logic r_vf;

    assign ce            = !(r_out_valid && !m_axis_tready && r_vf);
    assign s_axis_tready = ce;

    // stage 1: offsets from the center
    logic signed [32:0] dxs, dys;
    logic [32:0]        axn, ayn;
    logic               r_v1, r_nx1, r_ny1;
    logic [32:0]        r_ax1, r_ay1;

    assign dxs = $signed({s_axis_tdata[31], s_axis_tdata[31:0]}) - $signed({r_cx[31], r_cx});
    assign dys = $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) - $signed({r_cy[31], r_cy});
    assign axn = dxs[32] ? (~dxs + 33'd1) : dxs;
    assign ayn = dys[32] ? (~dys + 33'd1) : dys;

    // stage 2: pick the coordinate to stretch, form the dividend
    logic [32:0] s2_s, s2_o;
    logic        s2_far;
    logic        r_v2;
    t_div_st     r_d2;

    assign s2_s   = r_sy ? r_ay1 : r_ax1;
    assign s2_o   = r_sy ? r_ax1 : r_ay1;
    assign s2_far = (s2_s > {1'b0, r_short}) || (s2_o > {1'b0, r_long});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (ce) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ax1         <= axn;
            r_ay1         <= ayn;
            r_nx1         <= dxs[32];
            r_ny1         <= dys[32];
            r_d2.rem      <= 64'(s2_s[31:0]) * 64'(r_long);
            r_d2.q        <= '0;
            r_d2.c.other  <= s2_o[31:0];
            r_d2.c.nx     <= r_nx1;
            r_d2.c.ny     <= r_ny1;
            r_d2.c.far    <= s2_far;
        end
    end

    // divider chain, quotient bit 31 first
    logic    dv [33];
    t_div_st dd [33];

    assign dv[0] = r_v2;
    assign dd[0] = r_d2;

    for (genvar g = 0; g < 32; g++) begin : g_div
        epht_div_cell #(.K(31 - g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ce      (ce),
            .i_vld     (dv[g]),
            .i_d       (dd[g]),
            .i_divisor (r_short),
            .o_vld     (dv[g+1]),
            .o_d       (dd[g+1])
        );
    end

    // stage A: squares; stage B: circle test
    logic        r_va, r_vb;
    logic [63:0] r_sqq, r_sqo;
    logic [31:0] r_axa, r_aya;
    logic        r_nxa, r_nya, r_fara;
    t_norm_st    r_nb;
    logic [64:0] dsq;

    assign dsq = {1'b0, r_sqq} + {1'b0, r_sqo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (ce) begin
            r_va <= dv[32];
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sqq     <= 64'(dd[32].q) * 64'(dd[32].q);
            r_sqo     <= 64'(dd[32].c.other) * 64'(dd[32].c.other);
            r_axa     <= r_sy ? dd[32].c.other : dd[32].q;
            r_aya     <= r_sy ? dd[32].q : dd[32].c.other;
            r_nxa     <= dd[32].c.nx;
            r_nya     <= dd[32].c.ny;
            r_fara    <= dd[32].c.far;
            r_nb.ax      <= r_axa;
            r_nb.ay      <= r_aya;
            r_nb.nx      <= r_nxa;
            r_nb.ny      <= r_nya;
            r_nb.in_circ <= !r_fara && (dsq <= {1'b0, r_big_sq});
        end
    end

    // normalize so the larger magnitude reaches bit 30
    logic     nv [6];
    t_norm_st nd [6];

    assign nv[0] = r_vb;
    assign nd[0] = r_nb;

    for (genvar g = 0; g < 5; g++) begin : g_norm
        epht_norm_cell #(.S(16 >> g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_vld   (nv[g]),
            .i_d     (nd[g]),
            .o_vld   (nv[g+1]),
            .o_d     (nd[g+1])
        );
    end

    // CORDIC setup: fold the left half plane into the right one
    logic               c_xneg, c_yneg;
    logic signed [35:0] c_y;
    t_cordic_st         n_c0;
    t_cordic_st         r_c0;
    logic               r_vc;

    assign c_xneg = nd[5].nx && (nd[5].ax != 32'd0);
    assign c_yneg = nd[5].ny && (nd[5].ay != 32'd0);
    assign c_y    = c_yneg ? -$signed({4'd0, nd[5].ay}) : $signed({4'd0, nd[5].ay});

    always_comb begin
        n_c0.x       = $signed({4'd0, nd[5].ax});
        n_c0.y       = c_xneg ? -c_y : c_y;
        n_c0.z       = c_xneg ? (c_yneg ? -ANG_PI : ANG_PI) : '0;
        n_c0.zero    = (nd[5].ax == 32'd0) && (nd[5].ay == 32'd0);
        n_c0.in_circ = nd[5].in_circ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (ce) begin
            r_vc <= nv[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c0 <= n_c0;
        end
    end

    logic       cv [NSTEP+1];
    t_cordic_st cd [NSTEP+1];

    assign cv[0] = r_vc;
    assign cd[0] = r_c0;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
        epht_cordic_cell #(.I(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_vld   (cv[g]),
            .i_d     (cd[g]),
            .o_vld   (cv[g+1]),
            .o_d     (cd[g+1])
        );
    end

    // angle relative to start, floored into [0, 2pi)
    function automatic logic signed [34:0] f_floor_wrap(input logic signed [34:0] v);
        logic signed [34:0] res;
        res = v;
        if (v < 0) begin
            res = v + 35'(ANG_TWO_PI);
        end else if (v >= 35'(ANG_TWO_PI)) begin
            res = v - 35'(ANG_TWO_PI);
        end
        return res;
    endfunction

    logic signed [33:0] ang;
    logic               r_vd, r_ve;
    logic signed [34:0] r_dd, r_de, r_df;
    logic               r_in_d, r_in_e, r_in_f;

    assign ang = cd[NSTEP].zero ? '0 : cd[NSTEP].z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (ce) begin
            r_vd <= cv[NSTEP];
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dd   <= 35'(ang) - 35'(r_st2);
            r_in_d <= cd[NSTEP].in_circ;
            r_de   <= f_floor_wrap(r_dd);
            r_in_e <= r_in_d;
            r_df   <= f_floor_wrap(r_de);
            r_in_f <= r_in_e;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out_hit <= !r_zr && r_in_f && (r_full || (r_df <= 35'(r_sw_abs)));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_hit};

    `ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, r_vf && r_out_valid)
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v1)
    `ASSERT_IMPLIES(a_zero_radius_miss, i_clk, i_rst_n, r_out_valid && r_out_hit, !r_zr)

endmodule

// ===== hw/rtl/epht_div_cell.sv =====
module epht_div_cell import epht_pkg::*; #(
    parameter int K = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_vld,
    input  t_div_st     i_d,
    input  logic [31:0] i_divisor,
    output logic        o_vld,
    output t_div_st     o_d
);

    logic [64:0] trial;
    logic [64:0] diff;
    t_div_st     n_d;
    t_div_st     r_d;
    logic        r_vld;

    assign trial = {33'd0, i_divisor} << K;
    assign diff  = {1'b0, i_d.rem} - trial;

    always_comb begin
        n_d = i_d;
        if (!diff[64]) begin
            n_d.rem  = diff[63:0];
            n_d.q[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// ===== hw/rtl/epht_norm_cell.sv =====
module epht_norm_cell import epht_pkg::*; #(
    parameter int S = 1
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_ce,
    input  logic     i_vld,
    input  t_norm_st i_d,
    output logic     o_vld,
    output t_norm_st o_d
);

    localparam logic [31:0] LIM = 32'd1 << (31 - S);

    logic [31:0] m;
    t_norm_st    n_d;
    t_norm_st    r_d;
    logic        r_vld;

    assign m = (i_d.ax > i_d.ay) ? i_d.ax : i_d.ay;

    always_comb begin
        n_d = i_d;
        if (m < LIM) begin
            n_d.ax = i_d.ax << S;
            n_d.ay = i_d.ay << S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// ===== hw/rtl/epht_cordic_cell.sv =====
module epht_cordic_cell import epht_pkg::*; #(
    parameter int I = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ce,
    input  logic       i_vld,
    input  t_cordic_st i_d,
    output logic       o_vld,
    output t_cordic_st o_d
);

    localparam logic signed [33:0] ATN = $signed({6'd0, ATAN_LUT[I]});

    logic signed [35:0] dx;
    logic signed [35:0] dy;
    t_cordic_st         n_d;
    t_cordic_st         r_d;
    logic               r_vld;

    assign dx = i_d.y >>> I;
    assign dy = i_d.x >>> I;

    always_comb begin
        n_d = i_d;
        if (i_d.y < 0) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ATN;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ATN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule
